// File: src/lkv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared constants, types and state encoding for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned KEY_BITS   = 64;
  localparam int unsigned DATA_BITS  = 64;
  localparam int unsigned FIELD_BITS = 64;

  localparam int unsigned IDX_BITS  = $clog2(CAPACITY);
  localparam int unsigned RANK_BITS = $clog2(CAPACITY);
  localparam int unsigned OCC_BITS  = $clog2(CAPACITY + 1);

  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_PUT = 1'b1
  } lkv_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } lkv_state_e;

  typedef struct packed {
    logic load;
    logic match;
    logic commit;
  } lkv_cmd_t;

endpackage

// File: src/lkv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_if
// Request and response channel interfaces of the LRU key-value cache.
// ----------------------------------------------------------------------------
interface lkv_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] lookup_key;
  logic [63:0] write_data;

  modport source (output valid, output mode, output lookup_key, output write_data,
                  input ready);
  modport sink (input valid, input mode, input lookup_key, input write_data,
                output ready);
endinterface

interface lkv_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [63:0] read_data;
  logic        evicted;

  modport source (output valid, output hit, output read_data, output evicted,
                  input ready);
  modport sink (input valid, input hit, input read_data, input evicted,
                output ready);
endinterface

// File: src/lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative 16-entry key-value store with least-recently-used
// replacement, built from a sequencer and a register-based datapath.
//
// Channel   Direction  Payload
// req_i     in         mode, lookup_key, write_data
// rsp_o     out        hit, read_data, evicted
//
// Each request runs a match step, the parallel key compare over all entries,
// then an update step: rank update, entry write and result register load.
// Reset clears the valid marks, ranks and occupancy at once; no clearing pass.
// A result waits in the output register while the next request is accepted;
// the update step holds only while that register is still occupied.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
  input  logic  clk_i,
  input  logic  rst_ni,
  lkv_req_if.sink   req_i,
  lkv_rsp_if.source rsp_o
);
  import lkv_pkg::*;

  lkv_cmd_t cmd;
  logic     req_ready;
  logic     rsp_valid;

  lkv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  lkv_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .mode_i       (req_i.mode),
    .lookup_key_i (req_i.lookup_key),
    .write_data_i (req_i.write_data),
    .hit_o        (rsp_o.hit),
    .read_data_o  (rsp_o.read_data),
    .evicted_o    (rsp_o.evicted)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;

endmodule

// File: src/lkv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer for the cache: accepts a request, runs the match step and then
// the update step, and owns the response valid flag.
// ----------------------------------------------------------------------------
module lkv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output lkv_pkg::lkv_cmd_t cmd_o
);
  import lkv_pkg::*;

  lkv_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       commit;
  logic       accept;

  assign out_free = !out_valid_q || rsp_ready_i;

  always_comb begin
    commit      = (state_q == ST_UPDATE) && out_free;
    req_ready_o = (state_q == ST_IDLE) || commit;
    accept      = req_valid_i && req_ready_o;
    cmd_o.load   = accept;
    cmd_o.match  = (state_q == ST_MATCH);
    cmd_o.commit = commit;
    rsp_valid_o  = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_MATCH;
      end
      ST_MATCH: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (commit) state_d = accept ? ST_MATCH : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: src/lkv_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_datapath
// Entry storage, parallel key compare, LRU rank update and result register.
// ----------------------------------------------------------------------------
module lkv_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lkv_pkg::lkv_cmd_t cmd_i,
  input  logic              mode_i,
  input  logic [63:0]       lookup_key_i,
  input  logic [63:0]       write_data_i,
  output logic              hit_o,
  output logic [63:0]       read_data_o,
  output logic              evicted_o
);
  import lkv_pkg::*;

  logic                 valid_q [CAPACITY];
  logic [RANK_BITS-1:0] rank_q  [CAPACITY];
  logic [KEY_BITS-1:0]  key_mem [CAPACITY];
  logic [DATA_BITS-1:0] val_mem [CAPACITY];
  logic [OCC_BITS-1:0]  occ_q;

  logic                 mode_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [DATA_BITS-1:0] data_q;

  logic                 hit_q;
  logic                 full_q;
  logic [IDX_BITS-1:0]  tgt_q;
  logic [RANK_BITS-1:0] old_rank_q;
  logic [DATA_BITS-1:0] rdata_q;

  logic [CAPACITY-1:0]  match_vec;
  logic [IDX_BITS-1:0]  found_idx;
  logic [RANK_BITS-1:0] found_rank;
  logic [DATA_BITS-1:0] found_val;
  logic [IDX_BITS-1:0]  free_idx;
  logic [IDX_BITS-1:0]  victim_idx;
  logic                 full;
  logic                 insert;
  logic                 touch;

  assign full   = (occ_q == OCC_BITS'(CAPACITY));
  assign insert = !hit_q && (mode_q == MODE_PUT);
  assign touch  = hit_q || insert;

  always_comb begin
    found_idx  = '0;
    found_rank = '0;
    found_val  = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_vec[i] = valid_q[i] && (key_mem[i] == key_q);
      if (match_vec[i]) begin
        found_idx  = found_idx | IDX_BITS'(i);
        found_rank = found_rank | rank_q[i];
        found_val  = found_val | val_mem[i];
      end
      if (valid_q[i] && (rank_q[i] == RANK_BITS'(CAPACITY - 1))) begin
        victim_idx = victim_idx | IDX_BITS'(i);
      end
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = IDX_BITS'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      key_q  <= lookup_key_i[KEY_BITS-1:0];
      data_q <= write_data_i[DATA_BITS-1:0];
    end
    if (cmd_i.match) begin
      hit_q   <= |match_vec;
      full_q  <= full;
      rdata_q <= found_val;
      if (|match_vec) begin
        tgt_q      <= found_idx;
        old_rank_q <= found_rank;
      end else begin
        tgt_q      <= full ? victim_idx : free_idx;
        old_rank_q <= RANK_BITS'(CAPACITY - 1);
      end
    end
    if (cmd_i.commit) begin
      hit_o       <= hit_q;
      read_data_o <= hit_q ? FIELD_BITS'(rdata_q) : '0;
      evicted_o   <= insert && full_q;
      if (insert) begin
        key_mem[tgt_q] <= key_q;
        val_mem[tgt_q] <= data_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) begin
        valid_q[i] <= 1'b0;
        rank_q[i]  <= '0;
      end
      occ_q <= '0;
    end else if (cmd_i.commit && touch) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (IDX_BITS'(i) == tgt_q) begin
          rank_q[i]  <= '0;
          valid_q[i] <= 1'b1;
        end else if (valid_q[i] && (rank_q[i] < old_rank_q)) begin
          rank_q[i] <= rank_q[i] + RANK_BITS'(1);
        end
      end
      if (insert && !full_q) occ_q <= occ_q + OCC_BITS'(1);
    end
  end

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.match |-> $onehot0(match_vec))
    else $error("More than one valid entry matches the key.");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_BITS'(CAPACITY))
    else $error("Occupancy exceeds capacity.");

  a_occ_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && insert && !full_q) |=> (occ_q == $past(occ_q) + OCC_BITS'(1)))
    else $error("Insert into a free slot did not raise occupancy.");

  a_most_recent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && touch) |=> (rank_q[$past(tgt_q)] == '0) && valid_q[$past(tgt_q)])
    else $error("Touched entry is not the most recent valid entry.");

endmodule

// File: tb/sv/tb_lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Self-checking testbench for the LRU key-value cache. A shadow copy of the
// store predicts hit, read data and eviction for every accepted request.
// Each response transfer is compared in order against those predictions.
// Stimulus runs a directed sequence first, then random gets and puts drawn
// from small key pools so that hits, refills and evictions are frequent.
// Both channels idle at random. One phase holds the response side off for a
// long stretch so that the result register stays full and requests stall.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
  import lkv_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [63:0] read_data;
    logic        evicted;
  } access_result_t;

  localparam logic [63:0] KEY_MASK  = {64{1'b1}} >> (64 - KEY_BITS);
  localparam logic [63:0] DATA_MASK = {64{1'b1}} >> (64 - DATA_BITS);

  logic clk;
  logic rst_n;

  lkv_req_if req_if ();
  lkv_rsp_if rsp_if ();

  lru_key_value_cache u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic                 shadow_valid [CAPACITY];
  logic [63:0]          shadow_key   [CAPACITY];
  logic [63:0]          shadow_value [CAPACITY];
  logic [RANK_BITS-1:0] shadow_rank  [CAPACITY];
  int unsigned          shadow_count;

  access_result_t lookup_results_q [$];
  logic [63:0]    key_pool [$];
  int unsigned    mismatch_count;
  int unsigned    rsp_hold_left;
  bit             quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void promote_entry(int slot);
    for (int i = 0; i < CAPACITY; i++) begin
      if (shadow_valid[i] && i != slot && shadow_rank[i] < shadow_rank[slot]) begin
        shadow_rank[i] = shadow_rank[i] + 1'b1;
      end
    end
    shadow_rank[slot] = '0;
  endfunction

  function automatic access_result_t compute_access_result(lkv_mode_e mode,
                                                           logic [63:0] key_in,
                                                           logic [63:0] data_in);
    logic [63:0]    key;
    logic [63:0]    data;
    int             found;
    int             slot;
    access_result_t res;
    key   = key_in & KEY_MASK;
    data  = data_in & DATA_MASK;
    res   = '0;
    found = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (found < 0 && shadow_valid[i] && shadow_key[i] == key) begin
        found = i;
      end
    end
    if (found >= 0) begin
      res.hit       = 1'b1;
      res.read_data = shadow_value[found] & DATA_MASK;
      promote_entry(found);
    end else if (mode == MODE_PUT) begin
      slot = -1;
      if (shadow_count < CAPACITY) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (slot < 0 && !shadow_valid[i]) begin
            slot = i;
          end
        end
      end
      if (slot >= 0) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (shadow_valid[i]) begin
            shadow_rank[i] = shadow_rank[i] + 1'b1;
          end
        end
        shadow_valid[slot] = 1'b1;
        shadow_rank[slot]  = '0;
        shadow_count++;
      end else begin
        slot = 0;
        for (int i = 1; i < CAPACITY; i++) begin
          if (shadow_valid[i] && shadow_rank[i] > shadow_rank[slot]) begin
            slot = i;
          end
        end
        promote_entry(slot);
        res.evicted = 1'b1;
      end
      shadow_key[slot]   = key;
      shadow_value[slot] = data;
    end
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] string_key(string s);
    logic [63:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < 8; i++) begin
      k[8*i +: 8] = s[i];
    end
    return k;
  endfunction

  function automatic logic [63:0] random_string_key();
    string s;
    int    len;
    s   = "";
    len = $urandom_range(8);
    for (int i = 0; i < len; i++) begin
      s = {s, string'(byte'($urandom_range(32, 126)))};
    end
    return string_key(s);
  endfunction

  function automatic void refill_key_pool(int unsigned count);
    key_pool.delete();
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: key_pool.push_back(random_string_key());
        1: key_pool.push_back(rand64() & {{32{1'b0}}, {32{1'b1}}});
        default: key_pool.push_back(rand64());
      endcase
    end
  endfunction

  task automatic send_access(input lkv_mode_e mode, input logic [63:0] key,
                             input logic [63:0] data);
    if (!quiet && $urandom_range(99) < 6) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.mode       <= mode;
    req_if.lookup_key <= key;
    req_if.write_data <= data;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    lookup_results_q.push_back(compute_access_result(mode, key, data));
  endtask

  task automatic send_pool_access(int unsigned noise_pct);
    lkv_mode_e   mode;
    logic [63:0] key;
    mode = lkv_mode_e'($urandom_range(1));
    if ($urandom_range(99) < noise_pct || key_pool.size() == 0) begin
      key = rand64();
    end else begin
      key = key_pool[$urandom_range(key_pool.size() - 1)];
    end
    send_access(mode, key, rand64());
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rsp_hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_hold_left--;
      end else begin
        rsp_if.ready <= quiet || ($urandom_range(99) >= 6);
      end
    end
  end

  initial begin
    access_result_t expected;
    access_result_t actual;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) begin
        actual = '{hit: rsp_if.hit, read_data: rsp_if.read_data, evicted: rsp_if.evicted};
        if (lookup_results_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected transfer hit=%0b data=%h evicted=%0b",
                     $realtime, actual.hit, actual.read_data, actual.evicted);
          end
        end else begin
          expected = lookup_results_q.pop_front();
          if (actual !== expected) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: expected hit=%0b data=%h evicted=%0b, got hit=%0b data=%h evicted=%0b",
                       $realtime, expected.hit, expected.read_data, expected.evicted,
                       actual.hit, actual.read_data, actual.evicted);
            end
          end
        end
      end
    end
  end

  task automatic test_directed();
    send_access(MODE_GET, '0, '0);
    send_access(MODE_PUT, '0, '1);
    send_access(MODE_PUT, '1, '0);
    send_access(MODE_GET, '0, rand64());
    send_access(MODE_PUT, '1, 64'h5555_5555_aaaa_aaaa);
    send_access(MODE_GET, '1, '0);
    for (int i = 0; i < 14; i++) begin
      send_access(MODE_PUT, string_key($sformatf("key%0d", i)), rand64());
    end
    send_access(MODE_PUT, string_key("overflow"), rand64());
    send_access(MODE_GET, '0, '0);
    send_access(MODE_GET, '1, '0);
    send_access(MODE_PUT, string_key("zzzzzzzz"), rand64());
  endtask

  task automatic test_random_mix();
    for (int b = 0; b < 10; b++) begin
      refill_key_pool($urandom_range(10, 24));
      if ($urandom_range(1)) begin
        key_pool.push_back('0);
      end
      for (int i = 0; i < 100; i++) begin
        send_pool_access(5);
      end
    end
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    refill_key_pool(18);
    for (int i = 0; i < 400; i++) begin
      send_pool_access(5);
    end
    quiet = 1'b0;
  endtask

  task automatic test_output_stall();
    refill_key_pool(20);
    rsp_hold_left = 80;
    for (int i = 0; i < 40; i++) begin
      send_pool_access(10);
    end
  endtask

  task automatic test_miss_noise();
    for (int b = 0; b < 6; b++) begin
      refill_key_pool($urandom_range(14, 32));
      for (int i = 0; i < 100; i++) begin
        send_pool_access(30);
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    quiet             = 1'b0;
    mismatch_count    = 0;
    rsp_hold_left     = 0;
    shadow_count      = 0;
    req_if.valid      <= 1'b0;
    req_if.mode       <= MODE_GET;
    req_if.lookup_key <= '0;
    req_if.write_data <= '0;
    rsp_if.ready      <= 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
      shadow_rank[i]  = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_mix();
    test_back_to_back();
    test_output_stall();
    test_miss_noise();

    req_if.valid <= 1'b0;
    while (lookup_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && lookup_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
